FILE: rtl/tcw_pkg.sv
// Shared types, constants and state encoding for the text console writer.
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [APB_AW-1:0] REG_ADDR_BLANK_ATTR = 3'd0;

    localparam logic [7:0] BLANK_ATTR_RESET = 8'd15;

    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  char_code;
        logic [7:0]  color;
        logic [10:0] cell_index;
    } in_item_t;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [15:0] cell_word;
        logic        scrolled;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL,
        ST_BLANK_ROW,
        ST_CLEAR,
        ST_DONE
    } tcw_state_t;

endpackage

FILE: rtl/text_console_writer_top.sv
// Top level of the text console writer: APB registers, sequencer and screen memory.
// A put, read or unused-mode request passes through ST_DONE to the result
// register; a clear first sweeps every cell in ST_CLEAR; a put that scrolls first
// runs ST_SCROLL (one copy per cell of the upper rows through the screen
// memory's separate read and write ports) and then ST_BLANK_ROW (one write per
// cell of the bottom row). After reset the block runs a clearing pass over every
// cell with s_ready low; blank_attribute writes are taken during that pass.
// A finished result waits in the output register while the next request is
// accepted.
module text_console_writer_top #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  tcw_pkg::in_item_t           s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output tcw_pkg::out_item_t          m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tcw_pkg::APB_AW-1:0] paddr,
    input  logic [tcw_pkg::APB_DW-1:0] pwdata,
    output logic [tcw_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    logic [7:0]    blank_attr;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    tcw_apb_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .blank_attr (blank_attr)
    );

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .CELLS   (CELLS),
        .AW      (AW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .blank_attr (blank_attr),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

FILE: rtl/tcw_apb_regs.sv
// APB configuration register block holding the blank attribute.
module tcw_apb_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tcw_pkg::APB_AW-1:0] paddr,
    input  logic [tcw_pkg::APB_DW-1:0] pwdata,
    output logic [tcw_pkg::APB_DW-1:0] prdata,
    output logic                      pready,
    output logic [7:0]                blank_attr
);
    import tcw_pkg::*;

    logic [7:0] blank_attr_reg;
    logic [7:0] blank_attr_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        blank_attr_next = blank_attr_reg;
        if (wr_en && (paddr == REG_ADDR_BLANK_ATTR)) begin
            blank_attr_next = pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blank_attr_reg <= BLANK_ATTR_RESET;
        end else begin
            blank_attr_reg <= blank_attr_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_ADDR_BLANK_ATTR) begin
            prdata = APB_DW'(blank_attr_reg);
        end
    end

    assign blank_attr = blank_attr_reg;

endmodule

FILE: rtl/tcw_screen_ram.sv
// Screen cell memory with one write port and one registered read port.
module tcw_screen_ram #(
    parameter int DEPTH = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);
    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/tcw_ctrl.sv
// Sequencer: cursor tracking, sweep address unit and result register.
module tcw_ctrl #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS,
    parameter int CELLS   = COLUMNS * ROWS,
    parameter int AW      = $clog2(CELLS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tcw_pkg::in_item_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tcw_pkg::out_item_t m_data,
    input  logic [7:0]        blank_attr,
    output logic              ram_we,
    output logic [AW-1:0]     ram_waddr,
    output logic [15:0]       ram_wdata,
    output logic              ram_re,
    output logic [AW-1:0]     ram_raddr,
    input  logic [15:0]       ram_rdata
);
    import tcw_pkg::*;

    localparam int CUR_W      = $clog2(CELLS + COLUMNS);
    localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int MOVE_CELLS = COLUMNS * (ROWS - 1);

    localparam logic [AW-1:0]    LAST_ADDR = AW'(CELLS - 1);
    localparam logic [AW-1:0]    MOVE_ADDR = AW'(MOVE_CELLS);
    localparam logic [CUR_W-1:0] CELLS_CUR = CUR_W'(CELLS);
    localparam logic [CUR_W-1:0] COLS_CUR  = CUR_W'(COLUMNS);
    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);

    tcw_state_t state_reg, state_next;

    logic [CUR_W-1:0] cursor_reg, cursor_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [AW-1:0]    sweep_reg, sweep_next;
    logic             copy_valid_reg, copy_valid_next;
    logic [AW-1:0]    copy_addr_reg, copy_addr_next;
    logic             scrolled_reg, scrolled_next;
    logic             read_hit_reg, read_hit_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    logic             s_fire;
    logic             out_free;
    logic             is_bs;
    logic             is_nl;
    logic [CUR_W-1:0] cur_adv;
    logic             wrap;
    logic             idx_hit;
    logic [AW-1:0]    sweep_inc;
    logic [15:0]      blank_word;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign is_bs      = (s_data.char_code == CH_BACKSPACE);
    assign is_nl      = (s_data.char_code == CH_NEWLINE);
    assign cur_adv    = is_nl ? (cursor_reg + COLS_CUR - CUR_W'(col_reg))
                              : (cursor_reg + CUR_W'(1));
    assign wrap       = (cur_adv >= CELLS_CUR);
    assign idx_hit    = (32'(s_data.cell_index) < 32'(CELLS));
    assign sweep_inc  = (sweep_reg == LAST_ADDR) ? '0 : (sweep_reg + AW'(1));
    assign blank_word = {blank_attr, CH_SPACE};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (sweep_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    priority if (s_data.mode == MODE_PUT && !is_bs && wrap) begin
                        state_next = ST_SCROLL;
                    end else if (s_data.mode == MODE_CLEAR) begin
                        state_next = ST_CLEAR;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCROLL: begin
                if (sweep_reg == MOVE_ADDR) begin
                    state_next = ST_BLANK_ROW;
                end
            end
            ST_BLANK_ROW, ST_CLEAR: begin
                if (sweep_reg == LAST_ADDR) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cursor_next     = cursor_reg;
        col_next        = col_reg;
        sweep_next      = sweep_reg;
        copy_valid_next = 1'b0;
        copy_addr_next  = copy_addr_reg;
        scrolled_next   = scrolled_reg;
        read_hit_next   = read_hit_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = sweep_reg;
        ram_wdata       = blank_word;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        unique case (state_reg)
            ST_INIT: begin
                ram_we     = 1'b1;
                ram_wdata  = {BLANK_ATTR_RESET, CH_SPACE};
                sweep_next = sweep_inc;
            end
            ST_IDLE: begin
                sweep_next = '0;
                if (s_fire) begin
                    scrolled_next = 1'b0;
                    read_hit_next = 1'b0;
                    unique case (s_data.mode)
                        MODE_PUT: begin
                            if (is_bs) begin
                                if (cursor_reg != '0) begin
                                    ram_we      = 1'b1;
                                    ram_waddr   = AW'(cursor_reg - CUR_W'(1));
                                    cursor_next = cursor_reg - CUR_W'(1);
                                    col_next    = (col_reg == '0) ? COL_LAST
                                                                  : col_reg - COL_W'(1);
                                end
                            end else begin
                                if (!is_nl) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = AW'(cursor_reg);
                                    ram_wdata = {s_data.color, s_data.char_code};
                                end
                                col_next = (is_nl || col_reg == COL_LAST) ? '0
                                                                          : col_reg + COL_W'(1);
                                if (wrap) begin
                                    cursor_next   = cur_adv - COLS_CUR;
                                    scrolled_next = 1'b1;
                                end else begin
                                    cursor_next = cur_adv;
                                end
                            end
                        end
                        MODE_CLEAR: begin
                            cursor_next = '0;
                            col_next    = '0;
                        end
                        MODE_READ: begin
                            if (idx_hit) begin
                                ram_re        = 1'b1;
                                ram_raddr     = AW'(s_data.cell_index);
                                read_hit_next = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCROLL: begin
                ram_we    = copy_valid_reg;
                ram_waddr = copy_addr_reg;
                ram_wdata = ram_rdata;
                if (sweep_reg != MOVE_ADDR) begin
                    ram_re          = 1'b1;
                    ram_raddr       = sweep_reg + AW'(COLUMNS);
                    copy_valid_next = 1'b1;
                    copy_addr_next  = sweep_reg;
                    sweep_next      = sweep_inc;
                end
            end
            ST_BLANK_ROW, ST_CLEAR: begin
                ram_we     = 1'b1;
                sweep_next = sweep_inc;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.cursor_pos = 11'(cursor_reg);
                    m_data_next.cell_word  = read_hit_reg ? ram_rdata : 16'd0;
                    m_data_next.scrolled   = scrolled_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            cursor_reg     <= '0;
            col_reg        <= '0;
            sweep_reg      <= '0;
            copy_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            col_reg        <= col_next;
            sweep_reg      <= sweep_next;
            copy_valid_reg <= copy_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        copy_addr_reg <= copy_addr_next;
        scrolled_reg  <= scrolled_next;
        read_hit_reg  <= read_hit_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (cursor_reg < CELLS_CUR))
        else $error("cursor outside the screen while idle");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (32'(ram_waddr) < 32'(CELLS)))
        else $error("cell write outside the screen");

    a_copy_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCROLL && ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("scroll copy reads and writes the same cell");

    a_scroll_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && scrolled_reg) |-> (cursor_reg >= CUR_W'(MOVE_CELLS)))
        else $error("cursor not on the bottom row after a scroll");

    a_busy_no_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCROLL || state_reg == ST_CLEAR || state_reg == ST_INIT)
        |=> !m_valid_reg || $past(m_valid_reg))
        else $error("result raised during a sweep");
`endif

endmodule

FILE: tb/sv/tcw_checker.sv
// Checker for the text console writer: tracks the screen, predicts each result, compares.
module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  tcw_pkg::in_item_t           s_data,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  tcw_pkg::out_item_t          m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [tcw_pkg::APB_AW-1:0] paddr,
    input  logic [tcw_pkg::APB_DW-1:0] pwdata,
    input  logic [tcw_pkg::APB_DW-1:0] prdata,
    output int                         fail_count,
    output int                         pending
);
    import tcw_pkg::*;

    localparam int CELLS   = COLUMNS * ROWS;
    localparam int CELL_AW = $clog2(CELLS);

    logic [15:0] screen [0:CELLS-1];
    int          cursor;
    logic [7:0]  blank_attr;
    out_item_t   console_reports [$];
    int          errs;

    assign fail_count = errs;

    function automatic logic [15:0] blank_cell();
        return {blank_attr, CH_SPACE};
    endfunction

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++) begin
            screen[CELL_AW'(i)] = blank_cell();
        end
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errs++;
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
        end
    endfunction

    function automatic out_item_t emulate_console(in_item_t rq);
        out_item_t rs;
        rs = '0;
        case (rq.mode)
            MODE_PUT: begin
                if (rq.char_code == CH_BACKSPACE) begin
                    if (cursor > 0) begin
                        cursor--;
                        screen[CELL_AW'(cursor)] = blank_cell();
                    end
                end else begin
                    if (rq.char_code == CH_NEWLINE) begin
                        cursor += COLUMNS - (cursor % COLUMNS);
                    end else begin
                        screen[CELL_AW'(cursor)] = {rq.color, rq.char_code};
                        cursor++;
                    end
                    if (cursor >= CELLS) begin
                        for (int i = 0; i < COLUMNS * (ROWS - 1); i++) begin
                            screen[CELL_AW'(i)] = screen[CELL_AW'(i + COLUMNS)];
                        end
                        for (int i = COLUMNS * (ROWS - 1); i < CELLS; i++) begin
                            screen[CELL_AW'(i)] = blank_cell();
                        end
                        cursor -= COLUMNS;
                        rs.scrolled = 1'b1;
                    end
                end
            end
            MODE_CLEAR: begin
                blank_screen();
                cursor = 0;
            end
            MODE_READ: begin
                if (rq.cell_index < CELLS) begin
                    rs.cell_word = screen[CELL_AW'(rq.cell_index)];
                end
            end
            default: ;
        endcase
        rs.cursor_pos = cursor[10:0];
        return rs;
    endfunction

    initial begin
        errs = 0;
    end

    always @(posedge aclk) begin : watch
        out_item_t want;
        if (!aresetn) begin
            blank_attr = BLANK_ATTR_RESET;
            cursor = 0;
            blank_screen();
            console_reports.delete();
            pending <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (console_reports.size() == 0) begin
                    errs++;
                    $display("%0t: result expected none got 0x%0h", $time, m_data);
                end else begin
                    want = console_reports.pop_front();
                    check_field("cursor_pos", 32'(want.cursor_pos), 32'(m_data.cursor_pos));
                    check_field("cell_word", 32'(want.cell_word), 32'(m_data.cell_word));
                    check_field("scrolled", 32'(want.scrolled), 32'(m_data.scrolled));
                end
            end
            if (s_valid && s_ready) begin
                console_reports.push_back(emulate_console(s_data));
            end
            if (psel && penable && pready && paddr == REG_ADDR_BLANK_ATTR) begin
                if (pwrite) begin
                    blank_attr = pwdata[7:0];
                end else begin
                    check_field("blank_attribute", {24'd0, blank_attr}, prdata);
                end
            end
            pending <= console_reports.size();
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top for the text console writer: clock, reset, stimulus and verdict.
module tb_top;
    import tcw_pkg::*;

    localparam int CELLS = DEF_COLUMNS * DEF_ROWS;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [APB_AW-1:0] REG_ADDR_UNUSED = 3'd4;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_item_t           s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_item_t          m_data;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [APB_AW-1:0]  paddr   = '0;
    logic [APB_DW-1:0]  pwdata  = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    int fail_count;
    int pending;
    int sent;
    int burst_left;
    int stall_kind;
    int stall_left;
    int tick;

    text_console_writer_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tcw_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .fail_count(fail_count), .pending(pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #150000000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
            tick = 0;
        end else begin
            tick++;
            if (stall_left == 0) begin
                stall_kind = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 300);
            end else begin
                stall_left--;
            end
            case (stall_kind)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (tick % 5) != 0;
            endcase
        end
    end

    function automatic in_item_t make_request(logic [1:0] md, logic [7:0] ch, logic [10:0] idx);
        in_item_t r;
        r.mode       = md;
        r.char_code  = ch;
        r.color      = 8'($urandom_range(0, 255));
        r.cell_index = idx;
        return r;
    endfunction

    function automatic logic [10:0] any_index();
        return 11'($urandom_range(0, 2047));
    endfunction

    task automatic push_request(input in_item_t rq);
        int gap;
        s_valid <= 1'b1;
        s_data  <= rq;
        do @(posedge aclk); while (!s_ready);
        sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                gap = 0;
            end else if ($urandom_range(0, 15) == 0) begin
                gap = $urandom_range(20, 40);
            end else begin
                gap = $urandom_range(1, 8);
            end
            burst_left = $urandom_range(1, 30);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] a,
                              input logic [APB_DW-1:0] d);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= a;
        pwdata  <= d;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_blank_attr(input logic [7:0] attr);
        apb_access(1'b1, REG_ADDR_BLANK_ATTR, {24'd0, attr});
        apb_access(1'b0, REG_ADDR_BLANK_ATTR, '0);
    endtask

    task automatic random_phase(input int target);
        int kind;
        int len;
        in_item_t rq;
        while (sent < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 52) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100)
                                                  : $urandom_range(0, 12);
                repeat (len) push_request(make_request(MODE_PUT, 8'($urandom_range(0, 255)),
                                                       any_index()));
                if ($urandom_range(0, 3) != 0) begin
                    push_request(make_request(MODE_PUT, CH_NEWLINE, any_index()));
                end
            end else if (kind < 62) begin
                repeat ($urandom_range(1, 6)) begin
                    push_request(make_request(MODE_PUT, CH_BACKSPACE, any_index()));
                end
            end else if (kind < 77) begin
                rq = make_request(MODE_READ, 8'($urandom_range(0, 255)),
                                  11'($urandom_range(0, CELLS - 1)));
                if ($urandom_range(0, 7) == 0) begin
                    rq.cell_index = any_index();
                end
                push_request(rq);
            end else if (kind < 80) begin
                push_request(make_request(MODE_CLEAR, 8'($urandom_range(0, 255)),
                                          any_index()));
            end else if (kind < 83) begin
                push_request(make_request(MODE_UNUSED, 8'($urandom_range(0, 255)),
                                          any_index()));
            end else if (kind < 92) begin
                repeat ($urandom_range(1, 30)) begin
                    push_request(make_request(MODE_PUT, CH_NEWLINE, any_index()));
                end
            end else begin
                push_request(make_request(2'($urandom_range(0, 3)),
                                          8'($urandom_range(0, 255)), any_index()));
            end
        end
    endtask

    initial begin : stimulus
        in_item_t rq;
        sent = 0;
        burst_left = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        do @(posedge aclk); while (!s_ready);

        push_request(make_request(MODE_READ, 8'h00, 11'd0));
        push_request(make_request(MODE_READ, 8'h00, 11'(CELLS - 1)));
        push_request(make_request(MODE_READ, 8'h00, 11'(CELLS)));
        push_request(make_request(MODE_READ, 8'hFF, 11'h7FF));
        push_request(make_request(MODE_PUT, CH_BACKSPACE, 11'd0));
        rq = make_request(MODE_PUT, 8'hFF, 11'h7FF);
        rq.color = 8'hFF;
        push_request(rq);
        rq = make_request(MODE_PUT, 8'h00, 11'd0);
        rq.color = 8'h00;
        push_request(rq);
        push_request(make_request(MODE_PUT, 8'h41, 11'd0));
        push_request(make_request(MODE_PUT, CH_BACKSPACE, 11'd0));
        push_request(make_request(MODE_READ, 8'h00, 11'd2));
        push_request(make_request(MODE_PUT, CH_NEWLINE, 11'd0));
        rq = make_request(MODE_UNUSED, 8'hFF, 11'h7FF);
        rq.color = 8'hFF;
        push_request(rq);
        push_request(make_request(MODE_READ, 8'h00, 11'd0));
        settle();

        set_blank_attr(8'h00);
        push_request(make_request(MODE_PUT, CH_BACKSPACE, 11'd0));
        push_request(make_request(MODE_READ, 8'h00, 11'd79));
        push_request(make_request(MODE_READ, 8'h00, 11'd1));
        push_request(make_request(MODE_READ, 8'h00, 11'd3));
        push_request(make_request(MODE_CLEAR, 8'h00, 11'd0));
        push_request(make_request(MODE_READ, 8'h00, 11'(CELLS - 1)));
        push_request(make_request(MODE_PUT, CH_NEWLINE, 11'd0));
        settle();

        apb_access(1'b1, REG_ADDR_UNUSED, 32'h55);
        set_blank_attr(8'hFF);
        random_phase(sent + 160);
        settle();

        set_blank_attr(8'($urandom_range(0, 255)));
        random_phase(sent + 160);
        settle();

        set_blank_attr(8'h80);
        random_phase(sent + 160);
        settle();

        set_blank_attr(BLANK_ATTR_RESET);
        random_phase(sent + 160);
        settle();

        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
